FILE: rtl/dfia_pkg.sv
// shared types and codes of the deferred free index allocator
package dfia_pkg;

   localparam int IDX_W   = 10;
   localparam int CAP_W   = 11;
   localparam int DLY_W   = 4;
   localparam int FRAME_W = 32;
   localparam int RCNT_W  = 7;

   typedef enum logic [1:0] {
      MODE_ALLOCATE    = 2'd0,
      MODE_FREE        = 2'd1,
      MODE_FRAME_BEGIN = 2'd2,
      MODE_FRAME_END   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_EXHAUSTED  = 2'd1,
      STAT_QUEUE_FULL = 2'd2,
      STAT_IGNORED    = 2'd3
   } status_type;

   typedef enum logic {
      CSR_CAPACITY     = 1'b0,
      CSR_RETIRE_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [FRAME_W-1:0] stamp;
   } retire_entry_type;

   // queue control from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
      logic rd_req;
      logic rd_next;
   } rq_ctrl_type;

   // queue occupancy flags back to the sequencer
   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
   } rq_stat_type;

endpackage

FILE: rtl/dfia_retire_queue.sv
// retire queue: frame-stamped freed indices held in a synchronous memory
module dfia_retire_queue
   import dfia_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  rq_ctrl_type      ctrl,
   input  retire_entry_type push_entry,
   output retire_entry_type rd_entry,
   output rq_stat_type      stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   retire_entry_type mem [DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_adv;
   logic [PTR_W-1:0] rd_addr;

   always_comb begin
      head_adv = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      rd_addr  = ctrl.rd_next ? head_adv : head_ff;
      head_in  = ctrl.pop ? head_adv : head_ff;
      tail_in  = tail_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_entry;
      end
      if (ctrl.rd_req) begin
         rd_entry <= mem[rd_addr];
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(DEPTH));
   assign stat.one_left = (count_ff == CNT_W'(1));

endmodule

FILE: rtl/deferred_free_index_allocator_unit.sv
// top level of the deferred free index allocator
//
// usage
//   request channel: req_mode, req_slot_index and req_slot_valid are taken at
//   a rising edge with start high and busy low. every request gives exactly
//   one response, shown for one cycle with rsp_valid high; the receiver
//   cannot stall it, so it must be taken on that cycle.
//   response timing and busy
//   - free, frame end, fresh allocate, exhausted allocate, frame begin with
//     an empty retire queue: response in the cycle after the request, busy
//     stays low, so one request per cycle
//   - allocate from the free stack: a synchronous stack memory read, then
//     the response; busy while the pop state waits for the read data
//   - frame begin: one retire queue memory read per entry; busy until the
//     queue is empty or a young head or full stack ends the drain
//   configuration: csr_wr_en / csr_index / csr_wr_data, taken at once; the user
//   must write only while no request is in flight, the block does not enforce it
//   reset: synchronous; clears counters, pointers and frame number and loads
//   capacity 1024 and retire delay 3. memory contents are not cleared, only
//   written entries are ever read, so no clearing pass is needed
module deferred_free_index_allocator_unit
   import dfia_pkg::*;
#(
   parameter int SLOT_COUNT   = 1024,
   parameter int RETIRE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [IDX_W-1:0]  req_slot_index,
   input  logic              req_slot_valid,
   // response channel
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_granted_index,
   output logic [1:0]        rsp_status,
   output logic [RCNT_W-1:0] rsp_reclaimed_count,
   // configuration
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CAP_W-1:0]  csr_wr_data
);

   localparam int SP_W = $clog2(SLOT_COUNT + 1);
   localparam int SA_W = $clog2(SLOT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_DRAIN
   } state_type;

   // configuration registers
   logic [CAP_W-1:0]   cap_ff;
   logic [DLY_W-1:0]   delay_ff;

   // control state
   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   fresh_ff, fresh_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [RCNT_W-1:0]  moved_ff, moved_in;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [RCNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // free stack memory
   logic [IDX_W-1:0]   stack_mem [SLOT_COUNT];
   logic [IDX_W-1:0]   stack_rd_data;
   logic               stack_rd_en;
   logic               stack_wr_en;

   // retire queue link
   rq_ctrl_type        rq_ctrl;
   rq_stat_type        rq_stat;
   retire_entry_type   rq_push_entry;
   retire_entry_type   rq_rd_entry;

   logic               accept;
   mode_type           mode;
   logic [CAP_W-1:0]   cap_eff;
   logic [FRAME_W-1:0] age;
   logic               entry_ready;
   logic               stack_full;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign mode   = mode_type'(req_mode);

   // capacity above the slot count acts as the slot count
   always_comb begin
      cap_eff = cap_ff;
      if (32'(cap_ff) > 32'(SLOT_COUNT)) begin
         cap_eff = CAP_W'(SLOT_COUNT);
      end
   end

   // wrap-safe age of the entry at the head of the retire queue
   assign age         = frame_ff - rq_rd_entry.stamp;
   assign stack_full  = (sp_ff == SP_W'(SLOT_COUNT));
   assign entry_ready = (age >= FRAME_W'(delay_ff)) && !stack_full;

   assign rq_push_entry.index = req_slot_index;
   assign rq_push_entry.stamp = frame_ff;

   always_comb begin
      state_in      = state_ff;
      fresh_in      = fresh_ff;
      sp_in         = sp_ff;
      frame_in      = frame_ff;
      moved_in      = moved_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = '0;
      rsp_status_in = STAT_OK;
      rsp_count_in  = '0;
      stack_rd_en   = 1'b0;
      stack_wr_en   = 1'b0;
      rq_ctrl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode)
                  MODE_ALLOCATE: begin
                     if (sp_ff != '0) begin
                        // pop: read the top entry, answer once data returns
                        stack_rd_en = 1'b1;
                        sp_in       = sp_ff - 1'b1;
                        state_in    = ST_ALLOC;
                     end else if (fresh_ff < cap_eff) begin
                        rsp_valid_in = 1'b1;
                        rsp_index_in = fresh_ff[IDX_W-1:0];
                        fresh_in     = fresh_ff + 1'b1;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EXHAUSTED;
                     end
                  end
                  MODE_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (!req_slot_valid) begin
                        rsp_status_in = STAT_IGNORED;
                     end else if (rq_stat.full) begin
                        rsp_status_in = STAT_QUEUE_FULL;
                     end else begin
                        rq_ctrl.push = 1'b1;
                     end
                  end
                  MODE_FRAME_BEGIN: begin
                     moved_in = '0;
                     if (rq_stat.empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rq_ctrl.rd_req = 1'b1;
                        state_in       = ST_DRAIN;
                     end
                  end
                  MODE_FRAME_END: begin
                     rsp_valid_in = 1'b1;
                     frame_in     = frame_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = stack_rd_data;
            state_in     = ST_IDLE;
         end
         ST_DRAIN: begin
            if (entry_ready) begin
               // move the head entry onto the stack, fetch the next one if more remain
               stack_wr_en = 1'b1;
               sp_in       = sp_ff + 1'b1;
               rq_ctrl.pop = 1'b1;
               moved_in    = moved_ff + 1'b1;
               if (rq_stat.one_left) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = moved_ff + 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rq_ctrl.rd_req  = 1'b1;
                  rq_ctrl.rd_next = 1'b1;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_count_in = moved_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fresh_ff     <= '0;
         sp_ff        <= '0;
         frame_ff     <= '0;
         moved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         sp_ff        <= sp_in;
         frame_ff     <= frame_in;
         moved_ff     <= moved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(1024);
         delay_ff <= DLY_W'(3);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAPACITY:     cap_ff   <= csr_wr_data;
            CSR_RETIRE_DELAY: delay_ff <= csr_wr_data[DLY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // free stack: one write and one read port, registered read
   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[sp_ff[SA_W-1:0]] <= rq_rd_entry.index;
      end
      if (stack_rd_en) begin
         stack_rd_data <= stack_mem[sp_in[SA_W-1:0]];
      end
   end

   dfia_retire_queue #(
      .DEPTH (RETIRE_DEPTH)
   ) u_retire_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (rq_ctrl),
      .push_entry (rq_push_entry),
      .rd_entry   (rq_rd_entry),
      .stat       (rq_stat)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_index   = rsp_index_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_reclaimed_count = rsp_count_ff;

   // a stack pop returns to idle in the cycle after the pop state, once its memory data is there
   a_alloc_one_cycle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC |=> state_ff == ST_IDLE)
      else $error("stack read wait longer than one cycle");

   // the pop state is only entered with the pointer just decremented
   a_alloc_pop : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC |-> $past(sp_ff) == SP_W'(sp_ff + 1'b1))
      else $error("stack pointer not decremented by pop");

   // every end of a busy period delivers its response
   a_busy_response : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy request finished without a response");

   // the stack never holds more than the slot count
   a_stack_bound : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(SLOT_COUNT))
      else $error("stack pointer beyond slot count");

endmodule
